/* rtl/core/maximal_munch_lexer_core_assert.svh */
// Assertion macros used by the lexer checker.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef MAXIMAL_MUNCH_LEXER_CORE_ASSERT_SVH
`define MAXIMAL_MUNCH_LEXER_CORE_ASSERT_SVH

// Same-cycle implication, ignored while reset is high
`define MML_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high
`define MML_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset
`define MML_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mml_pkg.sv */
package mml_pkg;

  // Field widths
  localparam int OFFSET_BITS = 16;
  localparam int LENGTH_BITS = 8;
  localparam int KIND_W      = 6;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - KIND_W - OFFSET_BITS - LENGTH_BITS;

  // Token kinds: punctuators
  localparam logic [KIND_W-1:0] K_LPAREN   = 6'd0,  K_RPAREN   = 6'd1;
  localparam logic [KIND_W-1:0] K_LBRACE   = 6'd2,  K_RBRACE   = 6'd3;
  localparam logic [KIND_W-1:0] K_LBRACKET = 6'd4,  K_RBRACKET = 6'd5;
  localparam logic [KIND_W-1:0] K_COMMA    = 6'd6,  K_SEMI     = 6'd7;
  localparam logic [KIND_W-1:0] K_COLON    = 6'd8,  K_QUOTE    = 6'd9;
  localparam logic [KIND_W-1:0] K_DQUOTE   = 6'd10, K_DOT      = 6'd11;
  // Token kinds: operators
  localparam logic [KIND_W-1:0] K_ASSIGN   = 6'd12, K_EQ       = 6'd13;
  localparam logic [KIND_W-1:0] K_PLUS     = 6'd14, K_INC      = 6'd15;
  localparam logic [KIND_W-1:0] K_PLUS_EQ  = 6'd16, K_MINUS    = 6'd17;
  localparam logic [KIND_W-1:0] K_DEC      = 6'd18, K_MINUS_EQ = 6'd19;
  localparam logic [KIND_W-1:0] K_STAR     = 6'd20, K_STAR_EQ  = 6'd21;
  localparam logic [KIND_W-1:0] K_SLASH    = 6'd22, K_SLASH2   = 6'd23;
  localparam logic [KIND_W-1:0] K_SLASH_EQ = 6'd24, K_OR       = 6'd25;
  localparam logic [KIND_W-1:0] K_OR2      = 6'd26, K_OR_EQ    = 6'd27;
  localparam logic [KIND_W-1:0] K_OR2_EQ   = 6'd28, K_AND      = 6'd29;
  localparam logic [KIND_W-1:0] K_AND2     = 6'd30, K_AND_EQ   = 6'd31;
  localparam logic [KIND_W-1:0] K_AND2_EQ  = 6'd32, K_LT       = 6'd33;
  localparam logic [KIND_W-1:0] K_SHL      = 6'd34, K_LE       = 6'd35;
  localparam logic [KIND_W-1:0] K_SHL_EQ   = 6'd36, K_GT       = 6'd37;
  localparam logic [KIND_W-1:0] K_SHR      = 6'd38, K_GE       = 6'd39;
  localparam logic [KIND_W-1:0] K_SHR_EQ   = 6'd40;
  // Token kinds: the rest
  localparam logic [KIND_W-1:0] K_NEWLINE  = 6'd41, K_NUMBER   = 6'd42;
  localparam logic [KIND_W-1:0] K_IDENT    = 6'd43, K_UNKNOWN  = 6'd44;
  localparam logic [KIND_W-1:0] K_EOF      = 6'd45;

  // Special characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_X_UC  = 8'h58;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_X_LC  = 8'h78;

  // Optional kind: ok low means no token
  typedef struct packed {
    logic              ok;
    logic [KIND_W-1:0] kind;
  } kind_opt_t;

  // One token as it leaves the block
  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] length;
    logic                   last;
  } token_t;

  typedef struct packed {
    logic   valid;
    token_t tok;
  } result_t;

  function automatic kind_opt_t some(input logic [KIND_W-1:0] k);
    kind_opt_t r;
    r.ok   = 1'b1;
    r.kind = k;
    return r;
  endfunction

  // Character classes
  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic kind_opt_t punct_kind(input logic [7:0] c);
    kind_opt_t r;
    r = '0;
    unique case (c)
      "(":  r = some(K_LPAREN);
      ")":  r = some(K_RPAREN);
      "{":  r = some(K_LBRACE);
      "}":  r = some(K_RBRACE);
      "[":  r = some(K_LBRACKET);
      "]":  r = some(K_RBRACKET);
      ",":  r = some(K_COMMA);
      ";":  r = some(K_SEMI);
      ":":  r = some(K_COLON);
      "'":  r = some(K_QUOTE);
      "\"": r = some(K_DQUOTE);
      ".":  r = some(K_DOT);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic kind_opt_t single_kind(input logic [7:0] c);
    kind_opt_t r;
    r = '0;
    unique case (c)
      "=": r = some(K_ASSIGN);
      "+": r = some(K_PLUS);
      "-": r = some(K_MINUS);
      "*": r = some(K_STAR);
      "/": r = some(K_SLASH);
      "|": r = some(K_OR);
      "&": r = some(K_AND);
      "<": r = some(K_LT);
      ">": r = some(K_GT);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Doubled form of | & < >
  function automatic kind_opt_t double_kind(input logic [7:0] c);
    kind_opt_t r;
    r = '0;
    unique case (c)
      "|": r = some(K_OR2);
      "&": r = some(K_AND2);
      "<": r = some(K_SHL);
      ">": r = some(K_SHR);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Doubled form followed by '='
  function automatic kind_opt_t triple_kind(input logic [7:0] c);
    kind_opt_t r;
    r = '0;
    unique case (c)
      "|": r = some(K_OR2_EQ);
      "&": r = some(K_AND2_EQ);
      "<": r = some(K_SHL_EQ);
      ">": r = some(K_SHR_EQ);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Two-character operators other than the doubled | & < >
  function automatic kind_opt_t pair_kind(input logic [7:0] p, input logic [7:0] c);
    kind_opt_t r;
    r = '0;
    unique case (p)
      "=": if (c == "=") r = some(K_EQ);
      "+": begin
        if (c == "+") r = some(K_INC);
        else if (c == "=") r = some(K_PLUS_EQ);
      end
      "-": begin
        if (c == "-") r = some(K_DEC);
        else if (c == "=") r = some(K_MINUS_EQ);
      end
      "*": if (c == "=") r = some(K_STAR_EQ);
      "/": begin
        if (c == "/") r = some(K_SLASH2);
        else if (c == "=") r = some(K_SLASH_EQ);
      end
      "|": if (c == "=") r = some(K_OR_EQ);
      "&": if (c == "=") r = some(K_AND_EQ);
      "<": if (c == "=") r = some(K_LE);
      ">": if (c == "=") r = some(K_GE);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/mml_step.sv */
module mml_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [7:0]       src,
  input  logic             eoi,
  output mml_pkg::result_t res0,
  output mml_pkg::result_t res1
);
  import mml_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_OP1, ST_OP2, ST_NL, ST_ZERO, ST_HEX, ST_INT, ST_FRAC, ST_IDENT
  } lex_state_t;

  lex_state_t             state, state_next;
  logic [7:0]             pending, pending_next;
  logic [OFFSET_BITS-1:0] start_off, start_off_next;
  logic [OFFSET_BITS-1:0] byte_off, byte_off_next;
  logic [LENGTH_BITS-1:0] len_cnt, len_cnt_next;

  kind_opt_t              close_opt, beg_emit, dbl_opt, pair_opt, direct_opt, pk, sk;
  lex_state_t             beg_state;
  logic [7:0]             beg_pending;
  logic [LENGTH_BITS-1:0] beg_len, direct_len, len_inc;
  logic                   grow, restart;
  token_t                 t0, t1;
  logic                   v0, v1;

  // Token closed by the current state
  always_comb begin
    close_opt = '0;
    unique case (state)
      ST_OP1:   close_opt = single_kind(pending);
      ST_OP2:   close_opt = double_kind(pending);
      ST_NL:    close_opt = some(K_NEWLINE);
      ST_ZERO, ST_HEX, ST_INT, ST_FRAC: close_opt = some(K_NUMBER);
      ST_IDENT: close_opt = some(K_IDENT);
      default:  close_opt = '0;
    endcase
  end

  // Start of a new token from the idle condition
  always_comb begin
    pk          = punct_kind(src);
    sk          = single_kind(src);
    beg_emit    = '0;
    beg_state   = ST_IDLE;
    beg_len     = '0;
    beg_pending = '0;
    if (src == CH_NUL) begin
      beg_emit = some(K_EOF);
    end else if (pk.ok) begin
      beg_emit = pk;
    end else if (sk.ok) begin
      beg_state   = ST_OP1;
      beg_len     = LENGTH_BITS'(1);
      beg_pending = src;
    end else if (src == CH_NL) begin
      beg_state = ST_NL;
      beg_len   = LENGTH_BITS'(1);
    end else if (is_space(src)) begin
      beg_state = ST_IDLE;
    end else if (src == CH_ZERO) begin
      beg_state = ST_ZERO;
      beg_len   = LENGTH_BITS'(1);
    end else if (is_digit(src)) begin
      beg_state = ST_INT;
      beg_len   = LENGTH_BITS'(1);
    end else if (is_alpha(src)) begin
      beg_state = ST_IDENT;
      beg_len   = LENGTH_BITS'(1);
    end else begin
      beg_emit = some(K_UNKNOWN);
    end
  end

  // Continuation decision per state
  always_comb begin
    dbl_opt    = double_kind(pending);
    pair_opt   = pair_kind(pending, src);
    direct_opt = '0;
    direct_len = '0;
    grow       = 1'b0;
    restart    = 1'b0;
    state_next = state;
    unique case (state)
      ST_OP1: begin
        if (dbl_opt.ok && src == pending) begin
          state_next = ST_OP2;
          grow       = 1'b1;
        end else if (pair_opt.ok) begin
          direct_opt = pair_opt;
          direct_len = LENGTH_BITS'(2);
        end else begin
          restart = 1'b1;
        end
      end
      ST_OP2: begin
        if (src == CH_EQ) begin
          direct_opt = triple_kind(pending);
          direct_len = LENGTH_BITS'(3);
        end else begin
          restart = 1'b1;
        end
      end
      ST_NL: begin
        if (is_space(src)) grow = 1'b1;
        else restart = 1'b1;
      end
      ST_ZERO: begin
        if (src == CH_X_LC || src == CH_X_UC) begin
          state_next = ST_HEX;
          grow       = 1'b1;
        end else if (src == CH_DOT) begin
          state_next = ST_FRAC;
          grow       = 1'b1;
        end else if (is_digit(src)) begin
          state_next = ST_INT;
          grow       = 1'b1;
        end else begin
          restart = 1'b1;
        end
      end
      ST_HEX: begin
        if (is_hex(src)) grow = 1'b1;
        else restart = 1'b1;
      end
      ST_INT: begin
        if (src == CH_DOT) begin
          state_next = ST_FRAC;
          grow       = 1'b1;
        end else if (is_digit(src)) begin
          grow = 1'b1;
        end else begin
          restart = 1'b1;
        end
      end
      ST_FRAC: begin
        if (is_digit(src)) grow = 1'b1;
        else restart = 1'b1;
      end
      ST_IDENT: begin
        if (is_alpha(src) || is_digit(src) || src == CH_UNDER) grow = 1'b1;
        else restart = 1'b1;
      end
      default: restart = 1'b1;
    endcase
  end

  // Saturating length increment
  assign len_inc = (len_cnt == '1) ? len_cnt : len_cnt + LENGTH_BITS'(1);

  // Next state and up to two tokens
  always_comb begin
    pending_next   = pending;
    start_off_next = start_off;
    len_cnt_next   = len_cnt;
    byte_off_next  = byte_off + OFFSET_BITS'(1);
    t0             = '0;
    t1             = '0;
    v0             = 1'b0;
    v1             = 1'b0;
    if (eoi) begin
      byte_off_next  = '0;
      start_off_next = '0;
      len_cnt_next   = '0;
      pending_next   = '0;
      if (close_opt.ok) begin
        v0 = 1'b1;
        t0 = '{kind: close_opt.kind, start: start_off, length: len_cnt, last: 1'b0};
        v1 = 1'b1;
        t1 = '{kind: K_EOF, start: byte_off, length: '0, last: 1'b1};
      end else begin
        v0 = 1'b1;
        t0 = '{kind: K_EOF, start: byte_off, length: '0, last: 1'b1};
      end
    end else if (grow) begin
      len_cnt_next = len_inc;
    end else if (direct_opt.ok) begin
      pending_next = '0;
      len_cnt_next = '0;
      v0 = 1'b1;
      t0 = '{kind: direct_opt.kind, start: start_off, length: direct_len, last: 1'b1};
    end else if (restart) begin
      pending_next   = beg_pending;
      start_off_next = byte_off;
      len_cnt_next   = beg_len;
      if (close_opt.ok) begin
        v0 = 1'b1;
        t0 = '{kind: close_opt.kind, start: start_off, length: len_cnt,
               last: !beg_emit.ok};
        v1 = beg_emit.ok;
        t1 = '{kind: beg_emit.kind, start: byte_off, length: LENGTH_BITS'(1),
               last: 1'b1};
      end else begin
        v0 = beg_emit.ok;
        t0 = '{kind: beg_emit.kind, start: byte_off, length: LENGTH_BITS'(1),
               last: 1'b1};
      end
    end
  end

  // Results go straight to the output queue
  assign res0 = '{valid: go && v0, tok: t0};
  assign res1 = '{valid: go && v1, tok: t1};

  // Lexer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pending   <= '0;
      start_off <= '0;
      byte_off  <= '0;
      len_cnt   <= '0;
    end else if (go) begin
      if (eoi) state <= ST_IDLE;
      else if (direct_opt.ok && !grow) state <= ST_IDLE;
      else if (restart) state <= beg_state;
      else state <= state_next;
      pending   <= pending_next;
      start_off <= start_off_next;
      byte_off  <= byte_off_next;
      len_cnt   <= len_cnt_next;
    end
  end

endmodule

/* rtl/core/mml_outq.sv */
module mml_outq (
  input  logic             clk,
  input  logic             rst,
  input  mml_pkg::result_t res0,
  input  mml_pkg::result_t res1,
  input  logic             out_ready,
  output logic             out_valid,
  output mml_pkg::token_t  head,
  output logic             room
);
  import mml_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  token_t           entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic [1:0]       nwr;
  logic             pop;

  assign out_valid = (count != '0);
  assign head      = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  // Room for the worst case of two tokens from one byte
  assign room      = (count <= CNT_W'(DEPTH - 2));
  assign nwr        = 2'(res0.valid) + 2'(res1.valid);
  assign count_next = count + CNT_W'(nwr) - CNT_W'(pop);

  // Token storage
  always_ff @(posedge clk) begin
    if (res0.valid) entries[wr_ptr] <= res0.tok;
    if (res1.valid) entries[wr_ptr + PTR_W'(1)] <= res1.tok;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(nwr);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count_next;
    end
  end

endmodule

/* rtl/core/maximal_munch_lexer_core.sv */
// Path: a transferred byte is held in the input register, lexed when the token queue
// has room, and its tokens are written into the queue, which offers them on the master side.
// Throughput: one byte per cycle; a byte that yields two tokens needs two output
// transfers, and input stalls while the four-entry token queue has under two free slots.
// Reset (rst, synchronous): lexer returns to idle at offset 0, queue empties.
module maximal_munch_lexer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] source_byte
  input  logic        s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [mml_pkg::OUT_TDATA_W-1:0] m_tdata, // [5:0] token_kind, [21:6] token_start,
                                                  // [29:22] token_length, [31:30] zero
  output logic        m_tlast    // last_result
);
  import mml_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eoi;
  logic       go, room;
  result_t    res0, res1;
  token_t     head;

  assign go       = in_valid && room;
  assign s_tready = !in_valid || go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eoi  <= s_tlast;
    end
  end

  mml_step u_step (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .src  (in_byte),
    .eoi  (in_eoi),
    .res0 (res0),
    .res1 (res1)
  );

  mml_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .res0      (res0),
    .res1      (res1),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .head      (head),
    .room      (room)
  );

  assign m_tdata = {OUT_PAD_W'(0), head.length, head.start, head.kind};
  assign m_tlast = head.last;

endmodule

/* rtl/core/mml_checker.sv */
`include "maximal_munch_lexer_core_assert.svh"

module mml_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [mml_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tlast
);
  import mml_pkg::*;

  logic [KIND_W-1:0]      kind;
  logic [LENGTH_BITS-1:0] length;

  assign kind   = m_tdata[KIND_W-1:0];
  assign length = m_tdata[KIND_W+OFFSET_BITS +: LENGTH_BITS];

  // Queue is empty right after reset
  `MML_ASSERT_ALWAYS_NEXT(a_empty_after_reset, rst, !m_tvalid, "token offered after reset")

  // A stalled token holds
  `MML_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled token changed")

  // EOF always ends the tokens of its byte
  `MML_ASSERT_NOW(a_eof_last, m_tvalid && kind == K_EOF, m_tlast, "EOF token without last flag")

  // Punctuators and unknown bytes are single-byte tokens
  `MML_ASSERT_NOW(a_single_len, m_tvalid && (kind <= K_DOT || kind == K_UNKNOWN), length == LENGTH_BITS'(1), "single-byte token with wrong length")

endmodule

bind maximal_munch_lexer_core mml_checker u_mml_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import mml_pkg::*;

  localparam int          RANDOM_PER_PHASE = 150;
  localparam int          QUIET_LIMIT      = 3000;
  localparam int          MAX_PRINTED      = 40;
  localparam logic [5:0]  NO_TOKEN         = 6'h3F;

  typedef enum logic [3:0] {
    LX_IDLE, LX_OP1, LX_OP2, LX_NL, LX_ZERO, LX_HEX, LX_INT, LX_FRAC, LX_IDENT
  } lx_state_t;

  // One directed byte, with an optional hand-written token
  typedef struct {
    logic [7:0] ch;
    logic       eoi;
    bit         typed;
    token_t     tok;
  } script_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic        m_tlast;

  // Lexer shadow state
  lx_state_t        lx_state    = LX_IDLE;
  logic [7:0]       op_first    = 8'h00;
  logic [15:0]      tok_start   = 16'h0000;
  logic [15:0]      next_offset = 16'h0000;
  logic [7:0]       tok_len     = 8'h00;
  token_t           step_tokens[$];

  token_t           tokens_due[$];
  script_row_t      script_rows[$];
  logic [8:0]       burst[$];
  bit               override_on = 1'b0;
  token_t           override_tok;

  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_stall_pct = 0;
  int               mismatch_count = 0;
  int               bytes_sent     = 0;
  int               tokens_seen    = 0;
  int               quiet_cycles   = 0;

  string oper_text [29] = '{"=", "==", "+", "++", "+=", "-", "--", "-=", "*", "*=",
                            "/", "//", "/=", "|", "||", "|=", "||=", "&", "&&", "&=",
                            "&&=", "<", "<<", "<=", "<<=", ">", ">>", ">=", ">>="};
  string punct_text  = "()[]{},;:'\".";
  string letter_text = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  string tail_text   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
  string hex_text    = "0123456789abcdefABCDEF";

  maximal_munch_lexer_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- character classes
  function automatic bit is_blank(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_dec(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_ZERO + 8'd9;
  endfunction

  // Folding bit 5 maps upper case onto lower case
  function automatic bit is_letter(input logic [7:0] c);
    return (c | 8'h20) >= "a" && (c | 8'h20) <= "z";
  endfunction

  function automatic bit is_hexdig(input logic [7:0] c);
    return is_dec(c) || ((c | 8'h20) >= "a" && (c | 8'h20) <= "f");
  endfunction

  function automatic logic [5:0] punct_of(input logic [7:0] c);
    case (c)
      "(":     return K_LPAREN;
      ")":     return K_RPAREN;
      "{":     return K_LBRACE;
      "}":     return K_RBRACE;
      "[":     return K_LBRACKET;
      "]":     return K_RBRACKET;
      ",":     return K_COMMA;
      ";":     return K_SEMI;
      ":":     return K_COLON;
      "'":     return K_QUOTE;
      "\"":    return K_DQUOTE;
      CH_DOT:  return K_DOT;
      default: return NO_TOKEN;
    endcase
  endfunction

  function automatic logic [5:0] single_of(input logic [7:0] c);
    case (c)
      CH_EQ:   return K_ASSIGN;
      "+":     return K_PLUS;
      "-":     return K_MINUS;
      "*":     return K_STAR;
      "/":     return K_SLASH;
      "|":     return K_OR;
      "&":     return K_AND;
      "<":     return K_LT;
      ">":     return K_GT;
      default: return NO_TOKEN;
    endcase
  endfunction

  // Operator start followed by '='
  function automatic logic [5:0] eq_form_of(input logic [7:0] c);
    case (c)
      CH_EQ:   return K_EQ;
      "+":     return K_PLUS_EQ;
      "-":     return K_MINUS_EQ;
      "*":     return K_STAR_EQ;
      "/":     return K_SLASH_EQ;
      "|":     return K_OR_EQ;
      "&":     return K_AND_EQ;
      "<":     return K_LE;
      ">":     return K_GE;
      default: return NO_TOKEN;
    endcase
  endfunction

  // Operator start repeated
  function automatic logic [5:0] twin_of(input logic [7:0] c);
    case (c)
      "+":     return K_INC;
      "-":     return K_DEC;
      "/":     return K_SLASH2;
      "|":     return K_OR2;
      "&":     return K_AND2;
      "<":     return K_SHL;
      ">":     return K_SHR;
      default: return NO_TOKEN;
    endcase
  endfunction

  // Only | & < > may grow to three characters
  function automatic bit grows_to_three(input logic [7:0] c);
    return c == "|" || c == "&" || c == "<" || c == ">";
  endfunction

  // ---------------------------------------------------------------- lexer predictor
  function automatic void push_token(input logic [5:0] k, input logic [15:0] st,
                                     input logic [7:0] ln);
    token_t t;
    t.kind   = k;
    t.start  = st;
    t.length = ln;
    t.last   = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void bump_length();
    if (tok_len != 8'hFF) tok_len = tok_len + 8'd1;
  endfunction

  function automatic void go_idle();
    lx_state = LX_IDLE;
    op_first = 8'h00;
    tok_len  = 8'h00;
  endfunction

  function automatic void close_open_token();
    case (lx_state)
      LX_OP1:   push_token(single_of(op_first), tok_start, tok_len);
      LX_OP2:   push_token(twin_of(op_first), tok_start, tok_len);
      LX_NL:    push_token(K_NEWLINE, tok_start, tok_len);
      LX_ZERO, LX_HEX, LX_INT, LX_FRAC: push_token(K_NUMBER, tok_start, tok_len);
      LX_IDENT: push_token(K_IDENT, tok_start, tok_len);
      default:  ;
    endcase
    go_idle();
  endfunction

  // Byte seen between tokens
  function automatic void open_token(input logic [7:0] c);
    tok_start = next_offset;
    tok_len   = 8'd1;
    lx_state  = LX_IDLE;
    if (c == CH_NUL) begin
      push_token(K_EOF, next_offset, 8'd1);
    end else if (punct_of(c) != NO_TOKEN) begin
      push_token(punct_of(c), next_offset, 8'd1);
    end else if (single_of(c) != NO_TOKEN) begin
      lx_state = LX_OP1;
      op_first = c;
      return;
    end else if (c == CH_NL) begin
      lx_state = LX_NL;
      return;
    end else if (is_blank(c)) begin
      // skipped
    end else if (c == CH_ZERO) begin
      lx_state = LX_ZERO;
      return;
    end else if (is_dec(c)) begin
      lx_state = LX_INT;
      return;
    end else if (is_letter(c)) begin
      lx_state = LX_IDENT;
      return;
    end else begin
      push_token(K_UNKNOWN, next_offset, 8'd1);
    end
    tok_len = 8'h00;
  endfunction

  function automatic void restart(input logic [7:0] c);
    close_open_token();
    open_token(c);
  endfunction

  function automatic void feed_byte(input logic [7:0] c);
    case (lx_state)
      LX_OP1: begin
        if (grows_to_three(op_first) && c == op_first) begin
          lx_state = LX_OP2;
          bump_length();
        end else if (c == CH_EQ) begin
          push_token(eq_form_of(op_first), tok_start, 8'd2);
          go_idle();
        end else if (c == op_first && twin_of(op_first) != NO_TOKEN) begin
          push_token(twin_of(op_first), tok_start, 8'd2);
          go_idle();
        end else begin
          restart(c);
        end
      end
      LX_OP2: begin
        // the '=' form sits two codes after the doubled kind
        if (c == CH_EQ) begin
          push_token(twin_of(op_first) + 6'd2, tok_start, 8'd3);
          go_idle();
        end else begin
          restart(c);
        end
      end
      LX_NL: if (is_blank(c)) bump_length(); else restart(c);
      LX_ZERO: begin
        if (c == CH_X_LC || c == CH_X_UC) begin
          lx_state = LX_HEX;
          bump_length();
        end else if (c == CH_DOT) begin
          lx_state = LX_FRAC;
          bump_length();
        end else if (is_dec(c)) begin
          lx_state = LX_INT;
          bump_length();
        end else begin
          restart(c);
        end
      end
      LX_HEX: if (is_hexdig(c)) bump_length(); else restart(c);
      LX_INT: begin
        if (c == CH_DOT) begin
          lx_state = LX_FRAC;
          bump_length();
        end else if (is_dec(c)) begin
          bump_length();
        end else begin
          restart(c);
        end
      end
      LX_FRAC: if (is_dec(c)) bump_length(); else restart(c);
      LX_IDENT: begin
        if (is_letter(c) || is_dec(c) || c == CH_UNDER) bump_length();
        else restart(c);
      end
      default: open_token(c);
    endcase
  endfunction

  // Tokens caused by one accepted input transfer land in step_tokens
  function automatic void lex_byte(input logic [7:0] c, input logic eoi);
    step_tokens.delete();
    if (eoi) begin
      close_open_token();
      push_token(K_EOF, next_offset, 8'd0);
      go_idle();
      tok_start   = 16'h0000;
      next_offset = 16'h0000;
    end else begin
      feed_byte(c);
      next_offset = next_offset + 16'd1;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  function automatic logic [7:0] blank_char();
    case ($urandom_range(4))
      0:       return 8'd32;
      1:       return 8'd9;
      2:       return 8'd11;
      3:       return 8'd12;
      default: return 8'd13;
    endcase
  endfunction

  function automatic logic [7:0] digit_char();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic void push_char(input logic [7:0] c);
    burst.push_back({1'b0, c});
  endfunction

  function automatic void add_row(input logic [7:0] ch, input logic eoi, input bit typed,
                                  input logic [5:0] k, input logic [15:0] st,
                                  input logic [7:0] ln);
    script_row_t r;
    r.ch         = ch;
    r.eoi        = eoi;
    r.typed      = typed;
    r.tok.kind   = k;
    r.tok.start  = st;
    r.tok.length = ln;
    r.tok.last   = 1'b1;
    script_rows.push_back(r);
  endfunction

  // One lexeme of random content, mostly well formed, plus noise and end of input
  function automatic void gen_lexeme();
    int    pick;
    int    n;
    int    i;
    string txt;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 22) begin
      txt = oper_text[$urandom_range(28)];
      for (i = 0; i < txt.len(); i++) push_char(txt[i]);
    end else if (pick < 32) begin
      push_char(punct_text[$urandom_range(11)]);
    end else if (pick < 50) begin
      case ($urandom_range(3))
        0: begin
          n = $urandom_range(1, 4);
          for (i = 0; i < n; i++) push_char(digit_char());
          if ($urandom_range(1)) begin
            push_char(CH_DOT);
            n = $urandom_range(3);
            for (i = 0; i < n; i++) push_char(digit_char());
          end
        end
        1: begin
          push_char(CH_ZERO);
          push_char($urandom_range(1) ? CH_X_LC : CH_X_UC);
          n = $urandom_range(5);
          for (i = 0; i < n; i++) push_char(hex_text[$urandom_range(21)]);
        end
        default: begin
          push_char(CH_ZERO);
          n = $urandom_range(2);
          for (i = 0; i < n; i++) push_char(digit_char());
          if ($urandom_range(1)) push_char(CH_DOT);
        end
      endcase
    end else if (pick < 68) begin
      push_char(letter_text[$urandom_range(51)]);
      // rarely long enough to saturate the length
      n = ($urandom_range(99) == 0) ? $urandom_range(255, 265) : $urandom_range(6);
      for (i = 0; i < n; i++) push_char(tail_text[$urandom_range(62)]);
    end else if (pick < 76) begin
      push_char(CH_NL);
      n = $urandom_range(4);
      for (i = 0; i < n; i++) push_char($urandom_range(1) ? CH_NL : blank_char());
    end else if (pick < 84) begin
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) push_char(blank_char());
    end else if (pick < 96) begin
      b = 8'($urandom_range(255));
      push_char(b);
    end else if (pick < 98) begin
      push_char(CH_NUL);
    end else begin
      b = 8'($urandom_range(255));
      burst.push_back({1'b1, b});
    end
    if ($urandom_range(1)) push_char(blank_char());
  endfunction

  // Offer one byte, wait for its transfer, then record the tokens it should cause
  task automatic send_item(input logic [7:0] ch, input logic eoi);
    token_t t;
    int     i;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= eoi;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    lex_byte(ch, eoi);
    if (override_on) begin
      tokens_due.push_back(override_tok);
    end else begin
      for (i = 0; i < step_tokens.size(); i++) begin
        t      = step_tokens[i];
        t.last = (i == step_tokens.size() - 1);
        tokens_due.push_back(t);
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------- receiver side
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : token_check
    token_t want;
    if (!rst && m_tvalid && m_tready) begin
      tokens_seen++;
      if (tokens_due.size() == 0) begin
        report_mismatch($sformatf("token %h last %b with none expected", m_tdata, m_tlast));
      end else begin
        want = tokens_due.pop_front();
        if (m_tdata[5:0] !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d (start %0d)",
                                    m_tdata[5:0], want.kind, want.start));
        if (m_tdata[21:6] !== want.start)
          report_mismatch($sformatf("start %0d, want %0d (kind %0d)",
                                    m_tdata[21:6], want.start, want.kind));
        if (m_tdata[29:22] !== want.length)
          report_mismatch($sformatf("length %0d, want %0d (kind %0d start %0d)",
                                    m_tdata[29:22], want.length, want.kind, want.start));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("tlast %b, want %b (kind %0d start %0d)",
                                    m_tlast, want.last, want.kind, want.start));
        if (m_tdata[31:30] !== 2'b00)
          report_mismatch($sformatf("pad bits %b not zero", m_tdata[31:30]));
      end
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: %0d cycles without a transfer, %0d tokens outstanding",
               quiet_cycles, tokens_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main sequence
  initial begin : stim
    int          random_sent;
    int          i;
    logic [8:0]  w;
    string       txt;

    // Directed script: offsets restart at zero after each end of input
    add_row(8'h00,  1'b1, 1'b1, K_EOF,      16'd0,  8'd0);
    add_row("(",    1'b0, 1'b1, K_LPAREN,   16'd0,  8'd1);
    add_row("<",    1'b0, 1'b0, NO_TOKEN,   16'd0,  8'd0);
    add_row("<",    1'b0, 1'b0, NO_TOKEN,   16'd0,  8'd0);
    add_row(CH_EQ,  1'b0, 1'b1, K_SHL_EQ,   16'd1,  8'd3);
    add_row(CH_ZERO, 1'b0, 1'b0, NO_TOKEN,  16'd0,  8'd0);
    add_row(CH_X_LC, 1'b0, 1'b0, NO_TOKEN,  16'd0,  8'd0);
    add_row("F",    1'b0, 1'b0, NO_TOKEN,   16'd0,  8'd0);
    add_row(" ",    1'b0, 1'b1, K_NUMBER,   16'd4,  8'd3);
    add_row("1",    1'b0, 1'b0, NO_TOKEN,   16'd0,  8'd0);
    add_row(CH_DOT, 1'b0, 1'b0, NO_TOKEN,   16'd0,  8'd0);
    add_row(CH_NL,  1'b0, 1'b1, K_NUMBER,   16'd8,  8'd2);
    add_row("a",    1'b0, 1'b0, NO_TOKEN,   16'd0,  8'd0);
    add_row(CH_UNDER, 1'b0, 1'b0, NO_TOKEN, 16'd0,  8'd0);
    add_row(8'hFF,  1'b0, 1'b0, NO_TOKEN,   16'd0,  8'd0);
    add_row(CH_UNDER, 1'b0, 1'b1, K_UNKNOWN, 16'd14, 8'd1);
    add_row(CH_NUL, 1'b0, 1'b1, K_EOF,      16'd15, 8'd1);
    add_row("+",    1'b0, 1'b0, NO_TOKEN,   16'd0,  8'd0);
    add_row(8'h7F,  1'b0, 1'b0, NO_TOKEN,   16'd0,  8'd0);
    add_row(">",    1'b0, 1'b0, NO_TOKEN,   16'd0,  8'd0);
    add_row(8'hA5,  1'b1, 1'b0, NO_TOKEN,   16'd0,  8'd0);
    add_row(CH_ZERO, 1'b0, 1'b0, NO_TOKEN,  16'd0,  8'd0);
    add_row(CH_X_UC, 1'b0, 1'b0, NO_TOKEN,  16'd0,  8'd0);
    add_row(";",    1'b0, 1'b0, NO_TOKEN,   16'd0,  8'd0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (script_rows[i]) begin
      override_on  = script_rows[i].typed;
      override_tok = script_rows[i].tok;
      send_item(script_rows[i].ch, script_rows[i].eoi);
    end
    override_on = 1'b0;

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1:       begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 79; end
        3:       begin send_idle_pct = 27; recv_stall_pct = 27; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase

      random_sent = 0;
      while (random_sent < RANDOM_PER_PHASE) begin
        gen_lexeme();
        while (burst.size() != 0) begin
          w = burst.pop_front();
          send_item(w[7:0], w[8]);
          random_sent++;
        end
      end

      // Short newline run, an identifier, then a long number whose length saturates
      if (ph == 0) begin
        send_item(CH_NL, 1'b0);
        for (i = 0; i < 3; i++) send_item(blank_char(), 1'b0);
        txt = "ab_9z";
        for (i = 0; i < txt.len(); i++) send_item(txt[i], 1'b0);
        send_item(blank_char(), 1'b0);
        for (i = 0; i < 280; i++) send_item(digit_char(), 1'b0);
        send_item(CH_DOT, 1'b0);
        send_item(blank_char(), 1'b0);
      end

      // Hold the sender until every outstanding token has been seen
      s_tvalid <= 1'b0;
      do @(posedge clk); while (tokens_due.size() != 0);
    end

    repeat (8) @(posedge clk);

    $display("Covered %0d byte transfers and %0d tokens over five handshake phases,",
             bytes_sent, tokens_seen);
    $display("including saturated lengths, NUL and end-of-input; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0 && tokens_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/mml_pkg.sv
rtl/core/mml_step.sv
rtl/core/mml_outq.sv
rtl/core/maximal_munch_lexer_core.sv
rtl/core/mml_checker.sv
dv/tb.sv
